>>> sv/gplm_pkg.sv
// gplm_pkg: shared constants, types and the serpentine cell mapping for the
// grid pixel to led pulse mapper; depends on nothing
`timescale 1ns / 1ps

package gplm_pkg;

    localparam int TICK_W   = 15;
    localparam int SLOT_W   = 12;
    localparam int STRIP_W  = 2;
    localparam int POS_W    = 7;
    localparam int COORD_W  = 5;
    localparam int COLOR_W  = 24;
    localparam int CNT_W    = 5;
    localparam int CFG_IDX_W = 3;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE     = 3'd4;

    localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = 15'd65;
    localparam logic [TICK_W-1:0] ONE_LOW_RESET   = 15'd36;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = 15'd32;
    localparam logic [TICK_W-1:0] ZERO_LOW_RESET  = 15'd69;
    localparam logic [TICK_W-1:0] PAUSE_RESET     = 15'd2419;

    localparam logic [SLOT_W-1:0] PAUSE_SLOT = 12'd2736;

    localparam logic [COORD_W-1:0] MAX_ROW    = 5'd17;
    localparam logic [COORD_W-1:0] SIDE_COL   = 5'd18;
    localparam logic [COORD_W-1:0] FIRST_BOTTOM_ROW = 5'd9;

    // request kinds on tuser
    localparam logic REQ_PIXEL     = 1'b0;
    localparam logic REQ_FRAME_END = 1'b1;

    // beat counts minus one
    localparam logic [CNT_W-1:0] PIXEL_LAST_BEAT = 5'd23;
    localparam logic [CNT_W-1:0] PAUSE_LAST_BEAT = 5'd2;

    typedef struct packed {
        logic [STRIP_W-1:0] strip;
        logic [POS_W-1:0]   pos;
    } map_t;

    // remainder by nine of a coordinate, by compare and subtract
    function automatic logic [3:0] coord_mod9(logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] t;
        if (v >= 5'd27)
            t = v - 5'd27;
        else if (v >= 5'd18)
            t = v - 5'd18;
        else if (v >= 5'd9)
            t = v - 5'd9;
        else
            t = v;
        return t[3:0];
    endfunction

    // remainder by three of a value below nine
    function automatic logic [1:0] nine_mod3(logic [3:0] t);
        logic [3:0] d;
        if (t >= 4'd6)
            d = t - 4'd6;
        else if (t >= 4'd3)
            d = t - 4'd3;
        else
            d = t;
        return d[1:0];
    endfunction

    // quotient by three of a value below nine
    function automatic logic [1:0] nine_div3(logic [3:0] t);
        logic [1:0] q;
        if (t >= 4'd6)
            q = 2'd2;
        else if (t >= 4'd3)
            q = 2'd1;
        else
            q = 2'd0;
        return q;
    endfunction

    // serpentine mapping of an in-range cell onto strip and position
    // (x / 3) % 3 is the quotient by three of x % 9
    function automatic map_t map_cell(logic [COORD_W-1:0] row, logic [COORD_W-1:0] column);
        map_t               m;
        logic [COORD_W-1:0] rc;
        logic [3:0]         row_m9;
        logic [3:0]         col_m9;
        logic [3:0]         rc_m9;
        rc     = 5'd17 - column;
        row_m9 = coord_mod9(row);
        col_m9 = coord_mod9(column);
        rc_m9  = coord_mod9(rc);
        if (row < FIRST_BOTTOM_ROW) begin
            if (column == SIDE_COL) begin
                m.strip = nine_div3(row_m9);
                m.pos   = 7'd54 + {5'b00000, nine_mod3(row_m9)};
            end
            else begin
                m.strip = nine_div3(rc_m9);
                m.pos   = (7'd8 - {2'b00, row}) + 7'd9 * {5'b00000, nine_mod3(rc_m9)}
                          + ((column < 5'd9) ? 7'd0 : 7'd27);
            end
        end
        else begin
            if (column == SIDE_COL) begin
                m.strip = nine_div3(row_m9);
                m.pos   = 7'd57 + {5'b00000, nine_mod3(row_m9)};
            end
            else begin
                m.strip = nine_div3(col_m9);
                m.pos   = ((column < 5'd9) ? 7'd27 : 7'd0) + 7'd60
                          + 7'd9 * {5'b00000, nine_mod3(col_m9)} + {3'b000, row_m9};
            end
        end
        return m;
    endfunction

endpackage

>>> sv/grid_pixel_to_led_pulse_mapper_unit.sv
// grid_pixel_to_led_pulse_mapper_unit: top level, maps grid pixels to led
// strip positions and encodes each colour bit as a pulse word
// depends on gplm_pkg
`timescale 1ns / 1ps

// usage
//   s_axis: one request word per handshake; tuser is the kind (pixel or
//   frame end), tdata carries row, column and colour
//   m_axis: one pulse word per handshake, tlast marks the final pulse word
//   caused by a request
//   cfg: write enable, register index and data; written at any clock edge,
//   only meant to change while the block is idle
// flow: a request is loaded into the emit stage, each beat into the output
//   register; a pixel gives 24 pulse words, a frame end 3, one per cycle
//   while m_axis_tready holds; the beat counter of the emit stage counts
//   them, and the next request enters with no bubble between requests
// a pixel outside the grid is taken and dropped, giving no pulse word
// reset: emit stage and output register empty, timing registers at their
//   default values
// stall: when m_axis_tready is low the output register holds its word, the
//   emit stage holds its beat, and s_axis_tready falls once the stage is full
module grid_pixel_to_led_pulse_mapper_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // lowest bit up: row[4:0], column[9:5], color[33:10], zero fill
    input  logic [gplm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // lowest bit up: strip, slot, first_level, first_ticks, second_level,
    // second_ticks, zero fill
    output logic [gplm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [gplm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gplm_pkg::TICK_W-1:0]         cfg_data
);

    // timing registers
    logic [gplm_pkg::TICK_W-1:0] one_high_reg;
    logic [gplm_pkg::TICK_W-1:0] one_low_reg;
    logic [gplm_pkg::TICK_W-1:0] zero_high_reg;
    logic [gplm_pkg::TICK_W-1:0] zero_low_reg;
    logic [gplm_pkg::TICK_W-1:0] pause_reg;

    // emit stage
    logic                           busy_reg;
    logic                           is_pause_reg;
    logic [gplm_pkg::STRIP_W-1:0]   strip_reg;
    logic [gplm_pkg::SLOT_W-1:0]    slot_reg;
    logic [gplm_pkg::COLOR_W-1:0]   grb_reg;
    logic [gplm_pkg::CNT_W-1:0]     cnt_reg;

    // output register
    logic                           out_valid_reg;
    logic [gplm_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                           out_last_reg;

    // input fields
    logic [gplm_pkg::COORD_W-1:0]   in_row;
    logic [gplm_pkg::COORD_W-1:0]   in_column;
    logic [gplm_pkg::COLOR_W-1:0]   in_color;
    logic                           in_kind;
    logic                           in_take;
    logic                           in_on_grid;
    gplm_pkg::map_t                 in_map;

    logic                           advance;
    logic                           last_beat;
    logic                           bit_one;
    logic [gplm_pkg::TICK_W-1:0]    first_ticks;
    logic [gplm_pkg::TICK_W-1:0]    second_ticks;
    logic                           first_level;
    logic [gplm_pkg::OUT_DATA_W-1:0] beat_data;

    assign in_row    = s_axis_tdata[4:0];
    assign in_column = s_axis_tdata[9:5];
    assign in_color  = s_axis_tdata[33:10];
    assign in_kind   = s_axis_tuser;

    assign in_on_grid = (in_row <= gplm_pkg::MAX_ROW) && (in_column <= gplm_pkg::SIDE_COL);
    assign in_map     = gplm_pkg::map_cell(in_row, in_column);

    // a beat moves to the output register when it is empty or being drained
    assign advance   = busy_reg && (!out_valid_reg || m_axis_tready);
    assign last_beat = is_pause_reg ? (cnt_reg == gplm_pkg::PAUSE_LAST_BEAT)
                                    : (cnt_reg == gplm_pkg::PIXEL_LAST_BEAT);

    // next request enters as the final beat leaves
    assign s_axis_tready = !busy_reg || (advance && last_beat);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // pulse word for the current beat, msb of grb first
    assign bit_one      = grb_reg[gplm_pkg::COLOR_W-1];
    assign first_level  = !is_pause_reg;
    assign first_ticks  = is_pause_reg ? pause_reg : (bit_one ? one_high_reg : zero_high_reg);
    assign second_ticks = is_pause_reg ? pause_reg : (bit_one ? one_low_reg : zero_low_reg);
    assign beat_data    = {2'b00, second_ticks, 1'b0, first_ticks, first_level,
                           slot_reg, strip_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= gplm_pkg::ONE_HIGH_RESET;
            one_low_reg   <= gplm_pkg::ONE_LOW_RESET;
            zero_high_reg <= gplm_pkg::ZERO_HIGH_RESET;
            zero_low_reg  <= gplm_pkg::ZERO_LOW_RESET;
            pause_reg     <= gplm_pkg::PAUSE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gplm_pkg::REG_ONE_HIGH:  one_high_reg  <= cfg_data;
                gplm_pkg::REG_ONE_LOW:   one_low_reg   <= cfg_data;
                gplm_pkg::REG_ZERO_HIGH: zero_high_reg <= cfg_data;
                gplm_pkg::REG_ZERO_LOW:  zero_low_reg  <= cfg_data;
                gplm_pkg::REG_PAUSE:     pause_reg     <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // emit stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (in_take)
        begin
            // off-grid pixels are swallowed here
            busy_reg <= (in_kind == gplm_pkg::REQ_FRAME_END) || in_on_grid;
        end
        else if (advance && last_beat)
        begin
            busy_reg <= 1'b0;
        end
    end

    // emit stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            is_pause_reg <= (in_kind == gplm_pkg::REQ_FRAME_END);
            cnt_reg      <= '0;
            if (in_kind == gplm_pkg::REQ_FRAME_END)
            begin
                strip_reg <= '0;
                slot_reg  <= gplm_pkg::PAUSE_SLOT;
            end
            else
            begin
                strip_reg <= in_map.strip;
                slot_reg  <= gplm_pkg::SLOT_W'(in_map.pos) * 12'd24;
            end
            // green, red, blue
            grb_reg <= {in_color[15:8], in_color[23:16], in_color[7:0]};
        end
        else if (advance)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (is_pause_reg)
            begin
                strip_reg <= strip_reg + 2'd1;
            end
            else
            begin
                slot_reg <= slot_reg + 12'd1;
                grb_reg  <= {grb_reg[gplm_pkg::COLOR_W-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= beat_data;
            out_last_reg <= last_beat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> tb/gplm_pulse_checker.sv
// gplm_pulse_checker: watches the request, pulse and register ports of the
// mapper, predicts each pulse word and compares it; depends on gplm_pkg
`timescale 1ns / 1ps

module gplm_pulse_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // lowest bit up: row[4:0], column[9:5], color[33:10], zero fill
    input  logic [gplm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // lowest bit up: strip, slot, first_level, first_ticks, second_level,
    // second_ticks, zero fill
    input  logic [gplm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [gplm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gplm_pkg::TICK_W-1:0]         cfg_data,
    output int                                  outstanding,
    output int                                  mismatches,
    output int                                  words_checked
);

    typedef struct packed {
        logic [gplm_pkg::STRIP_W-1:0] strip;
        logic [gplm_pkg::SLOT_W-1:0]  slot;
        logic                         first_level;
        logic [gplm_pkg::TICK_W-1:0]  first_ticks;
        logic                         second_level;
        logic [gplm_pkg::TICK_W-1:0]  second_ticks;
        logic                         last;
    } pulse_t;

    pulse_t                      pending_pulses[$];
    logic [gplm_pkg::TICK_W-1:0] one_high;
    logic [gplm_pkg::TICK_W-1:0] one_low;
    logic [gplm_pkg::TICK_W-1:0] zero_high;
    logic [gplm_pkg::TICK_W-1:0] zero_low;
    logic [gplm_pkg::TICK_W-1:0] pause_len;
    int                          fail_count = 0;
    int                          seen_count = 0;

    assign mismatches    = fail_count;
    assign words_checked = seen_count;

    // expected pulse words for one request, in emission order
    function automatic void queue_pulses(input logic kind,
                                         input logic [gplm_pkg::COORD_W-1:0] row,
                                         input logic [gplm_pkg::COORD_W-1:0] column,
                                         input logic [gplm_pkg::COLOR_W-1:0] color);
        int         r;
        int         c;
        int         strip_no;
        int         pos;
        logic [23:0] grb;
        logic       bit_val;
        pulse_t     p;
        r = row;
        c = column;
        if (kind == gplm_pkg::REQ_FRAME_END)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p.strip        = gplm_pkg::STRIP_W'(k);
                p.slot         = gplm_pkg::PAUSE_SLOT;
                p.first_level  = 1'b0;
                p.first_ticks  = pause_len;
                p.second_level = 1'b0;
                p.second_ticks = pause_len;
                p.last         = (k == 2);
                pending_pulses.push_back(p);
            end
            return;
        end
        // cell off the grid: dropped
        if (r > gplm_pkg::MAX_ROW || c > gplm_pkg::SIDE_COL)
            return;
        if (r < gplm_pkg::FIRST_BOTTOM_ROW)
        begin
            if (c == gplm_pkg::SIDE_COL)
            begin
                strip_no = (r / 3) % 3;
                pos      = 54 + r % 3;
            end
            else
            begin
                strip_no = ((17 - c) / 3) % 3;
                pos      = (8 - r) + ((17 - c) % 3) * 9 + (c / 9) * 27;
            end
        end
        else
        begin
            if (c == gplm_pkg::SIDE_COL)
            begin
                strip_no = (r / 3) % 3;
                pos      = 57 + (r - 9) % 3;
            end
            else
            begin
                strip_no = (c / 3) % 3;
                pos      = (1 - c / 9) * 27 + 60 + 9 * (c % 3) + r % 9;
            end
        end
        grb = {color[15:8], color[23:16], color[7:0]};
        for (int k = 0; k < 24; k++)
        begin
            bit_val        = grb[23 - k];
            p.strip        = gplm_pkg::STRIP_W'(strip_no);
            p.slot         = gplm_pkg::SLOT_W'(pos * 24 + k);
            p.first_level  = 1'b1;
            p.first_ticks  = bit_val ? one_high : zero_high;
            p.second_level = 1'b0;
            p.second_ticks = bit_val ? one_low : zero_low;
            p.last         = (k == 23);
            pending_pulses.push_back(p);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pulse_t want;
        pulse_t got;
        if (!rst_n)
        begin
            one_high  <= gplm_pkg::ONE_HIGH_RESET;
            one_low   <= gplm_pkg::ONE_LOW_RESET;
            zero_high <= gplm_pkg::ZERO_HIGH_RESET;
            zero_low  <= gplm_pkg::ZERO_LOW_RESET;
            pause_len <= gplm_pkg::PAUSE_RESET;
            pending_pulses.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.strip        = m_axis_tdata[1:0];
                got.slot         = m_axis_tdata[13:2];
                got.first_level  = m_axis_tdata[14];
                got.first_ticks  = m_axis_tdata[29:15];
                got.second_level = m_axis_tdata[30];
                got.second_ticks = m_axis_tdata[45:31];
                got.last         = m_axis_tlast;
                seen_count++;
                if (pending_pulses.size() == 0)
                begin
                    $error("unexpected pulse word: strip %0d slot %0d", got.strip, got.slot);
                    fail_count++;
                end
                else
                begin
                    want = pending_pulses.pop_front();
                    check_field("strip", want.strip, got.strip);
                    check_field("slot", want.slot, got.slot);
                    check_field("first_level", want.first_level, got.first_level);
                    check_field("first_ticks", want.first_ticks, got.first_ticks);
                    check_field("second_level", want.second_level, got.second_level);
                    check_field("second_ticks", want.second_ticks, got.second_ticks);
                    check_field("last", want.last, got.last);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                queue_pulses(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[9:5],
                             s_axis_tdata[33:10]);
            if (cfg_we)
            begin
                case (cfg_index)
                    gplm_pkg::REG_ONE_HIGH:  one_high  <= cfg_data;
                    gplm_pkg::REG_ONE_LOW:   one_low   <= cfg_data;
                    gplm_pkg::REG_ZERO_HIGH: zero_high <= cfg_data;
                    gplm_pkg::REG_ZERO_LOW:  zero_low  <= cfg_data;
                    gplm_pkg::REG_PAUSE:     pause_len <= cfg_data;
                    default:                 ;
                endcase
            end
            outstanding <= pending_pulses.size();
        end
    end

endmodule

>>> tb/tb.sv
// tb: stimulus and verdict for the grid pixel to led pulse mapper; drives
// requests, timing registers and back-pressure, and relies on gplm_pulse_checker
// for prediction; depends on gplm_pkg and the mapper top level
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HIGH       = 6;
    localparam int CLK_LOW        = 6;
    localparam int RESET_CYCLES   = 6;
    // no handshake on either side for this long means the block is stuck
    localparam int WATCHDOG_LIMIT = 3000;
    // settle time after the last pulse word, longer than one whole pixel
    localparam int DRAIN_GAP      = 32;
    localparam int NUM_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 60;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [gplm_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = gplm_pkg::REQ_PIXEL;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [gplm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            cfg_we        = 1'b0;
    logic [gplm_pkg::CFG_IDX_W-1:0]  cfg_index     = gplm_pkg::REG_ONE_HIGH;
    logic [gplm_pkg::TICK_W-1:0]     cfg_data      = '0;

    int outstanding;
    int mismatches;
    int words_checked;

    // idle percentages of the two sides, changed between phases
    int tx_idle_pct = 14;
    int rx_idle_pct = 57;
    int idle_cycles = 0;

    // run statistics for the summary
    int pixels_sent     = 0;
    int frame_ends_sent = 0;
    int dropped_sent    = 0;

    // loop variables of the main sequence
    int                           phase;
    int                           produced;
    int                           pick;
    logic                         kind;
    logic [gplm_pkg::COORD_W-1:0] row;
    logic [gplm_pkg::COORD_W-1:0] column;
    logic [gplm_pkg::COLOR_W-1:0] color;

    always
    begin
        #(CLK_LOW) clk = 1'b1;
        #(CLK_HIGH) clk = 1'b0;
    end

    grid_pixel_to_led_pulse_mapper_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gplm_pulse_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .outstanding   (outstanding),
        .mismatches    (mismatches),
        .words_checked (words_checked)
    );

    // receiver back-pressure, decided afresh every cycle
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // watchdog on cycles with no word moving on either stream
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // present one request word and hold it until the handshake; valid stays
    // high when the next word follows at once, so it is never toggled in one step
    task automatic send_request(input logic req_kind, input logic [gplm_pkg::COORD_W-1:0] r,
                                input logic [gplm_pkg::COORD_W-1:0] c,
                                input logic [gplm_pkg::COLOR_W-1:0] rgb);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req_kind;
        s_axis_tdata  <= {6'b000000, rgb, c, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (req_kind == gplm_pkg::REQ_FRAME_END)
            frame_ends_sent++;
        else if (r > gplm_pkg::MAX_ROW || c > gplm_pkg::SIDE_COL)
            dropped_sent++;
        else
            pixels_sent++;
    endtask

    // sender holds off until every predicted pulse word has come out, then
    // leaves a quiet gap before the next step
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // one register write; the enable stays high across back-to-back writes
    task automatic write_reg(input logic [gplm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gplm_pkg::TICK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // load all five timing registers, optionally poking the unused indexes too
    task automatic program_timing(input logic [gplm_pkg::TICK_W-1:0] one_hi,
                                  input logic [gplm_pkg::TICK_W-1:0] one_lo,
                                  input logic [gplm_pkg::TICK_W-1:0] zero_hi,
                                  input logic [gplm_pkg::TICK_W-1:0] zero_lo,
                                  input logic [gplm_pkg::TICK_W-1:0] pause_v, input bit stray);
        write_reg(gplm_pkg::REG_ONE_HIGH, one_hi);
        write_reg(gplm_pkg::REG_ONE_LOW, one_lo);
        write_reg(gplm_pkg::REG_ZERO_HIGH, zero_hi);
        write_reg(gplm_pkg::REG_ZERO_LOW, zero_lo);
        write_reg(gplm_pkg::REG_PAUSE, pause_v);
        // writes past the last register must leave the timing untouched
        if (stray)
            for (int i = int'(gplm_pkg::REG_PAUSE) + 1; i < 2 ** gplm_pkg::CFG_IDX_W; i++)
                write_reg(gplm_pkg::CFG_IDX_W'(i), gplm_pkg::TICK_W'($urandom_range(0, 32767)));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset timing: grid corners, the side column in
        // both halves, the column 8/9 seam and the row 8/9 seam
        send_request(gplm_pkg::REQ_PIXEL, 5'd0, 5'd0, 24'h000000);
        send_request(gplm_pkg::REQ_PIXEL, 5'd0, 5'd17, 24'hFFFFFF);
        send_request(gplm_pkg::REQ_PIXEL, 5'd8, 5'd0, 24'hAAAAAA);
        send_request(gplm_pkg::REQ_PIXEL, 5'd8, 5'd17, 24'h555555);
        send_request(gplm_pkg::REQ_PIXEL, 5'd0, gplm_pkg::SIDE_COL, 24'hFF0000);
        send_request(gplm_pkg::REQ_PIXEL, 5'd8, gplm_pkg::SIDE_COL, 24'h00FF00);
        send_request(gplm_pkg::REQ_PIXEL, gplm_pkg::FIRST_BOTTOM_ROW, gplm_pkg::SIDE_COL,
                     24'h0000FF);
        send_request(gplm_pkg::REQ_PIXEL, gplm_pkg::MAX_ROW, gplm_pkg::SIDE_COL, 24'h800001);
        send_request(gplm_pkg::REQ_PIXEL, gplm_pkg::FIRST_BOTTOM_ROW, 5'd0, 24'h012345);
        send_request(gplm_pkg::REQ_PIXEL, gplm_pkg::MAX_ROW, 5'd17, 24'(($urandom)));
        send_request(gplm_pkg::REQ_PIXEL, 5'd8, 5'd8, 24'h7F80FE);
        send_request(gplm_pkg::REQ_PIXEL, 5'd8, 5'd9, 24'h81017F);
        send_request(gplm_pkg::REQ_PIXEL, gplm_pkg::FIRST_BOTTOM_ROW, 5'd8, 24'hC3A55A);
        send_request(gplm_pkg::REQ_PIXEL, gplm_pkg::FIRST_BOTTOM_ROW, 5'd9, 24'h3C5AA5);
        send_request(gplm_pkg::REQ_PIXEL, 5'd11, 5'd5, 24'h00FFFF);
        // frame end: row, column and colour are don't-care
        send_request(gplm_pkg::REQ_FRAME_END, 5'd0, 5'd0, 24'h000000);
        send_request(gplm_pkg::REQ_FRAME_END, 5'd31, 5'd31, 24'hFFFFFF);
        // cells off the grid are taken and dropped
        send_request(gplm_pkg::REQ_PIXEL, 5'd18, 5'd0, 24'hFFFFFF);
        send_request(gplm_pkg::REQ_PIXEL, 5'd31, 5'd31, 24'hFFFFFF);
        send_request(gplm_pkg::REQ_PIXEL, 5'd0, 5'd19, 24'h123456);
        send_request(gplm_pkg::REQ_PIXEL, gplm_pkg::MAX_ROW, 5'd31, 24'hABCDEF);
        // a good pixel straight after a dropped one
        send_request(gplm_pkg::REQ_PIXEL, 5'd4, 5'd12, 24'hF0F00F);
        wait_for_drain();

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            // sender light / receiver heavy, then swapped, then no idling
            if (phase < 2)
            begin
                tx_idle_pct = 14;
                rx_idle_pct = 57;
            end
            else if (phase < 4)
            begin
                tx_idle_pct = 57;
                rx_idle_pct = 14;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // timing setting for this phase; phase 0 keeps the reset values
            case (phase)
                1: program_timing(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0);
                2: program_timing(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b0);
                3: program_timing(gplm_pkg::TICK_W'($urandom_range(0, 32767)),
                                  gplm_pkg::TICK_W'($urandom_range(0, 32767)),
                                  gplm_pkg::TICK_W'($urandom_range(0, 32767)),
                                  gplm_pkg::TICK_W'($urandom_range(0, 32767)),
                                  gplm_pkg::TICK_W'($urandom_range(0, 32767)), 1'b1);
                4: program_timing(15'h5555, 15'h2AAA, 15'h2AAA, 15'h5555, 15'd1, 1'b0);
                5: program_timing(gplm_pkg::ONE_HIGH_RESET, gplm_pkg::ONE_LOW_RESET,
                                  gplm_pkg::ZERO_HIGH_RESET, gplm_pkg::ZERO_LOW_RESET,
                                  gplm_pkg::PAUSE_RESET, 1'b1);
                default: ;
            endcase

            // random part: mostly on-grid pixels, some frame ends, a few
            // off-grid cells that do not count towards the phase
            produced = 0;
            while (produced < ITEMS_PER_PHASE)
            begin
                pick  = $urandom_range(0, 99);
                color = gplm_pkg::COLOR_W'($urandom);
                if ($urandom_range(0, 7) == 0)
                    color = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                if (pick < 10)
                begin
                    kind   = gplm_pkg::REQ_FRAME_END;
                    row    = gplm_pkg::COORD_W'($urandom);
                    column = gplm_pkg::COORD_W'($urandom);
                    produced++;
                end
                else if (pick < 16)
                begin
                    kind = gplm_pkg::REQ_PIXEL;
                    if ($urandom_range(0, 1))
                    begin
                        row    = gplm_pkg::COORD_W'($urandom_range(18, 31));
                        column = gplm_pkg::COORD_W'($urandom);
                    end
                    else
                    begin
                        row    = gplm_pkg::COORD_W'($urandom);
                        column = gplm_pkg::COORD_W'($urandom_range(19, 31));
                    end
                end
                else
                begin
                    kind   = gplm_pkg::REQ_PIXEL;
                    row    = gplm_pkg::COORD_W'($urandom_range(0, 17));
                    column = gplm_pkg::COORD_W'($urandom_range(0, 18));
                    produced++;
                end
                send_request(kind, row, column, color);
                // now and then the sender waits for the block to run dry
                if ($urandom_range(0, 99) < 3)
                    wait_for_drain();
            end
            wait_for_drain();
        end

        $display("ran %0d on-grid pixels, %0d frame ends and %0d off-grid cells, %0d pulse words",
                 pixels_sent, frame_ends_sent, dropped_sent, words_checked);
        $display("over %0d timing settings incl. all-zero, all-ones and unused-index writes",
                 NUM_PHASES);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
